// ===== rtl/core/shake_gesture_detector_unit_assert.svh =====
// Assertion macros for the shake gesture detector.
// Both macros sample on clk; the first one is quiet while rst_n is low.
`ifndef SHAKE_GESTURE_DETECTOR_UNIT_ASSERT_SVH
`define SHAKE_GESTURE_DETECTOR_UNIT_ASSERT_SVH

// Check that runs only outside reset.
`define SGD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs during reset.
`define SGD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/sgd_pkg.sv =====
// ----------------------------------------------------------------------------
// sgd_pkg
// Types and constants shared by the shake gesture detector and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sgd_pkg;

    // Flip time window
    localparam int WIN_DEPTH = 16;
    localparam int IDX_W     = $clog2(WIN_DEPTH);
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MOTION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FLIP_GAP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLIPS_NEEDED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_GAP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD         = 3'd5;

    // Reset values of the registers
    localparam logic [14:0] MIN_MOTION_RST   = 15'd20;
    localparam logic [23:0] MAX_FLIP_GAP_RST = 24'd120000;
    localparam logic [4:0]  FLIPS_NEEDED_RST = 5'd3;
    localparam logic [23:0] WINDOW_RST       = 24'd700000;
    localparam logic [23:0] IDLE_GAP_RST     = 24'd250000;
    localparam logic [23:0] HOLD_RST         = 24'd1500000;

    // Request kinds
    localparam logic [1:0] KIND_REL  = 2'd0;
    localparam logic [1:0] KIND_ABS  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // Motion direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] value;
        logic [31:0]        timestamp_us;
    } in_item_t;

    typedef struct packed {
        logic       shake;
        logic       enlarged;
        logic [4:0] flips_held;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PRUNE,
        ST_STORE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/shake_gesture_detector_unit.sv =====
// ----------------------------------------------------------------------------
// shake_gesture_detector_unit
// Pointer shake detector: tracks direction flips of strong X motions in a
// window of flip times held in a small synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid / in_ready     | in_data (kind, value, timestamp_us)
//  out     | output    | out_valid / out_ready   | out_data (shake, enlarged, flips_held)
//  cfg     | input     | cfg_we (no wait)        | cfg_index, cfg_data
//
//  A request that is not a flip passes ST_EVAL, then ST_DONE, before its result
//  is registered. A flip walks the stored flip times one RAM read a cycle in
//  ST_PRUNE, then passes ST_STORE and ST_DONE; the RAM read port sets the pace
//  of the walk, and ST_DONE waits while the output holds a result not yet taken.
//  One request is worked on at a time; a new one is taken while the last
//  result still waits in the output register.
//  rst_n clears all control state and restores the register defaults at once;
//  the RAM needs no clearing, only entries below the flip count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module shake_gesture_detector_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire sgd_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output sgd_pkg::out_item_t                 out_data,
    input  wire logic                          cfg_we,
    input  wire logic [sgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sgd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sgd_pkg::*;

    // configuration
    logic [14:0] min_motion_reg;
    logic [23:0] max_flip_gap_reg;
    logic [4:0]  flips_needed_reg;
    logic [23:0] window_reg;
    logic [23:0] idle_gap_reg;
    logic [23:0] hold_reg;

    // control and scalar state
    state_t         state_reg, state_next;
    in_item_t       req_reg, req_next;
    logic [1:0]     last_dir_reg, last_dir_next;
    logic [31:0]    last_time_reg, last_time_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]    base_reg, base_next;
    logic           base_valid_reg, base_valid_next;
    logic [31:0]    last_seen_reg, last_seen_next;
    logic           hold_active_reg, hold_active_next;
    logic [31:0]    deadline_reg, deadline_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic           rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic           shake_reg, shake_next;
    logic           out_valid_reg, out_valid_next;
    out_item_t      out_data_reg, out_data_next;

    // flip time RAM
    logic [31:0]    flip_mem [WIN_DEPTH];
    logic [31:0]    rd_data_reg;
    logic           mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic           mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]    mem_wdata;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            flip_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= flip_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_motion_reg   <= MIN_MOTION_RST;
            max_flip_gap_reg <= MAX_FLIP_GAP_RST;
            flips_needed_reg <= FLIPS_NEEDED_RST;
            window_reg       <= WINDOW_RST;
            idle_gap_reg     <= IDLE_GAP_RST;
            hold_reg         <= HOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_MOTION:   min_motion_reg   <= cfg_data[14:0];
                REG_MAX_FLIP_GAP: max_flip_gap_reg <= cfg_data;
                REG_FLIPS_NEEDED: flips_needed_reg <= cfg_data[4:0];
                REG_WINDOW:       window_reg       <= cfg_data;
                REG_IDLE_GAP:     idle_gap_reg     <= cfg_data;
                REG_HOLD:         hold_reg         <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_dir_reg    <= DIR_NONE;
            last_time_reg   <= '0;
            cnt_reg         <= '0;
            base_reg        <= '0;
            base_valid_reg  <= 1'b0;
            last_seen_reg   <= '0;
            hold_active_reg <= 1'b0;
            deadline_reg    <= '0;
            rd_idx_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            kept_reg        <= '0;
            shake_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_dir_reg    <= last_dir_next;
            last_time_reg   <= last_time_next;
            cnt_reg         <= cnt_next;
            base_reg        <= base_next;
            base_valid_reg  <= base_valid_next;
            last_seen_reg   <= last_seen_next;
            hold_active_reg <= hold_active_next;
            deadline_reg    <= deadline_next;
            rd_idx_reg      <= rd_idx_next;
            rd_pend_reg     <= rd_pend_next;
            kept_reg        <= kept_next;
            shake_reg       <= shake_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        logic signed [16:0] dx;
        logic [16:0]        mag;
        logic               take;
        logic               big_move;
        logic [1:0]         dir;
        logic               expired;
        logic               issue;
        logic [CNT_W-1:0]   new_cnt;
        logic [31:0]        tick_age;

        state_next       = state_reg;
        req_next         = req_reg;
        last_dir_next    = last_dir_reg;
        last_time_next   = last_time_reg;
        cnt_next         = cnt_reg;
        base_next        = base_reg;
        base_valid_next  = base_valid_reg;
        last_seen_next   = last_seen_reg;
        hold_active_next = hold_active_reg;
        deadline_next    = deadline_reg;
        rd_idx_next      = rd_idx_reg;
        rd_pend_next     = 1'b0;
        kept_next        = kept_reg;
        shake_next       = shake_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        mem_re           = 1'b0;
        mem_raddr        = rd_idx_reg[IDX_W-1:0];
        mem_we           = 1'b0;
        mem_waddr        = kept_reg[IDX_W-1:0];
        mem_wdata        = rd_data_reg;

        dx       = '0;
        take     = 1'b0;
        expired  = 1'b0;
        issue    = 1'b0;
        new_cnt  = '0;
        tick_age = req_reg.timestamp_us - deadline_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                shake_next = 1'b0;
                state_next = ST_DONE;
                case (req_reg.kind)
                    KIND_REL:
                    begin
                        dx   = {req_reg.value[15], req_reg.value};
                        take = 1'b1;
                    end
                    KIND_ABS:
                    begin
                        expired = base_valid_reg &&
                                  ((req_reg.timestamp_us - last_seen_reg) >
                                   {8'd0, idle_gap_reg});
                        last_seen_next = req_reg.timestamp_us;
                        base_next      = req_reg.value;
                        base_valid_next = 1'b1;
                        if (base_valid_reg && !expired)
                        begin
                            dx   = 17'({req_reg.value[15], req_reg.value} -
                                       {base_reg[15], base_reg});
                            take = 1'b1;
                        end
                    end
                    KIND_TICK:
                    begin
                        if (hold_active_reg && !tick_age[31])
                        begin
                            hold_active_next = 1'b0;
                            deadline_next    = '0;
                        end
                    end
                    default: ;
                endcase

                // zero counts as negative; dx never reaches -65536
                mag      = dx[16] ? 17'(-dx) : 17'(dx);
                big_move = (mag >= {2'd0, min_motion_reg});
                dir      = (!dx[16] && (dx != '0)) ? DIR_POS : DIR_NEG;
                if (take && big_move)
                begin
                    last_dir_next  = dir;
                    last_time_next = req_reg.timestamp_us;
                    if ((last_dir_reg != DIR_NONE) && (dir != last_dir_reg) &&
                        ((req_reg.timestamp_us - last_time_reg) <=
                         {8'd0, max_flip_gap_reg}))
                    begin
                        rd_idx_next = '0;
                        kept_next   = '0;
                        state_next  = ST_PRUNE;
                    end
                end
            end

            ST_PRUNE:
            begin
                // compact the window in place: reads run ahead of writes
                issue = (rd_idx_reg < cnt_reg);
                if (issue)
                begin
                    mem_re       = 1'b1;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    if ((req_reg.timestamp_us - rd_data_reg) <= {8'd0, window_reg})
                    begin
                        mem_we    = 1'b1;
                        kept_next = kept_reg + 1'b1;
                    end
                end
                if (!issue && !rd_pend_reg)
                begin
                    state_next = ST_STORE;
                end
            end

            ST_STORE:
            begin
                // new flip is always young enough; dropped only on a full window
                new_cnt = kept_reg;
                if (32'(cnt_reg) < WIN_DEPTH)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = req_reg.timestamp_us;
                    new_cnt   = kept_reg + 1'b1;
                end
                cnt_next = new_cnt;
                if (32'(new_cnt) >= 32'(flips_needed_reg))
                begin
                    cnt_next         = '0;
                    shake_next       = 1'b1;
                    hold_active_next = 1'b1;
                    deadline_next    = req_reg.timestamp_us + {8'd0, hold_reg};
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.shake      = shake_reg;
                    out_data_next.enlarged   = hold_active_reg;
                    out_data_next.flips_held = 5'(cnt_reg);
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/sgd_checker.sv =====
// ----------------------------------------------------------------------------
// sgd_checker
// Port-level checks for the shake gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shake_gesture_detector_unit_assert.svh"

module sgd_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire sgd_pkg::out_item_t out_data
);
    import sgd_pkg::*;

    `SGD_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |-> !out_valid, "result shown during reset")

    `SGD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

    // a shake empties the window and starts the hold
    `SGD_ASSERT(a_shake_state, out_valid && out_data.shake |-> out_data.enlarged && (out_data.flips_held == 5'd0), "shake without hold or with flips left")

    `SGD_ASSERT(a_flips_range, out_valid |-> (32'(out_data.flips_held) <= WIN_DEPTH), "flip count beyond window depth")

    // a request is taken only after the previous one produced its result
    `SGD_ASSERT(a_one_busy, in_valid && in_ready |=> !in_ready, "request taken back to back")

endmodule

bind shake_gesture_detector_unit sgd_checker u_sgd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== sim/shake_gesture_checker.sv =====
// ----------------------------------------------------------------------------
// shake_gesture_checker
// Watches the request, result and register ports of the shake detector, keeps
// its own copy of the detector state, predicts one result per accepted request
// and compares every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------

module shake_gesture_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire sgd_pkg::in_item_t              in_data,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire sgd_pkg::out_item_t             out_data,
    input  wire logic                           cfg_we,
    input  wire logic [sgd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sgd_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                  fails,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sgd_pkg::*;

    // register copies
    logic [14:0] min_motion;
    logic [23:0] max_gap;
    logic [4:0]  flips_needed;
    logic [23:0] window_len;
    logic [23:0] idle_gap;
    logic [23:0] hold_len;

    // detector state copy
    logic [1:0]  last_dir;
    logic [31:0] last_motion_t;
    logic [31:0] flip_t [WIN_DEPTH];
    int          flip_cnt;
    int          abs_base;
    logic        abs_valid;
    logic [31:0] abs_seen;
    logic        hold_on;
    logic [31:0] hold_dl;

    sgd_pkg::out_item_t due_results [$];

    function automatic void prune_flips(logic [31:0] t);
        int kept;
        kept = 0;
        for (int i = 0; i < flip_cnt && i < WIN_DEPTH; i++) begin
            if (t - flip_t[i] <= {8'd0, window_len}) begin
                flip_t[kept] = flip_t[i];
                kept++;
            end
        end
        flip_cnt = kept;
    endfunction

    // returns 1 when this motion completes a shake
    function automatic logic take_motion(int dx, logic [31:0] t);
        logic [1:0] dir;
        int         lim;
        lim = int'(min_motion);
        if (dx > -lim && dx < lim)
            return 1'b0;
        // a zero delta counts as negative
        dir = (dx > 0) ? DIR_POS : DIR_NEG;
        if (last_dir != DIR_NONE && dir != last_dir
            && (t - last_motion_t) <= {8'd0, max_gap}) begin
            if (flip_cnt < WIN_DEPTH) begin
                flip_t[flip_cnt] = t;
                flip_cnt++;
            end
            prune_flips(t);
            if (flip_cnt >= int'(flips_needed)) begin
                flip_cnt      = 0;
                last_dir      = dir;
                last_motion_t = t;
                return 1'b1;
            end
        end
        last_dir      = dir;
        last_motion_t = t;
        return 1'b0;
    endfunction

    function automatic sgd_pkg::out_item_t step_detector(sgd_pkg::in_item_t req);
        sgd_pkg::out_item_t res;
        logic               hit;
        int                 v;
        logic [31:0]        t;
        logic [31:0]        age;
        hit = 1'b0;
        v   = int'($signed(req.value));
        t   = req.timestamp_us;
        case (req.kind)
            KIND_REL: hit = take_motion(v, t);
            KIND_ABS:
            begin
                if (abs_valid && (t - abs_seen) > {8'd0, idle_gap})
                    abs_valid = 1'b0;
                abs_seen = t;
                if (!abs_valid) begin
                    abs_base  = v;
                    abs_valid = 1'b1;
                end
                else begin
                    // full precision delta, never wrapped to 16 bits
                    hit      = take_motion(v - abs_base, t);
                    abs_base = v;
                end
            end
            KIND_TICK:
            begin
                age = t - hold_dl;
                if (hold_on && !age[31]) begin
                    hold_on = 1'b0;
                    hold_dl = '0;
                end
            end
            default: ;
        endcase
        if (hit) begin
            hold_dl = t + {8'd0, hold_len};
            hold_on = 1'b1;
        end
        res.shake      = hit;
        res.enlarged   = hold_on;
        res.flips_held = flip_cnt[4:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sgd_pkg::out_item_t want;
        sgd_pkg::out_item_t got;
        if (!rst_n) begin
            min_motion    = MIN_MOTION_RST;
            max_gap       = MAX_FLIP_GAP_RST;
            flips_needed  = FLIPS_NEEDED_RST;
            window_len    = WINDOW_RST;
            idle_gap      = IDLE_GAP_RST;
            hold_len      = HOLD_RST;
            last_dir      = DIR_NONE;
            last_motion_t = '0;
            flip_cnt      = 0;
            abs_base      = 0;
            abs_valid     = 1'b0;
            abs_seen      = '0;
            hold_on       = 1'b0;
            hold_dl       = '0;
            fails         = 0;
            due_results.delete();
            pending <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                got = out_data;
                if (due_results.size() == 0) begin
                    $error("result with no request outstanding: shake %0d enlarged %0d flips %0d",
                           got.shake, got.enlarged, got.flips_held);
                    fails++;
                end
                else begin
                    want = due_results.pop_front();
                    if (got.shake !== want.shake) begin
                        $error("shake: expected %0d, actual %0d", want.shake, got.shake);
                        fails++;
                    end
                    if (got.enlarged !== want.enlarged) begin
                        $error("enlarged: expected %0d, actual %0d",
                               want.enlarged, got.enlarged);
                        fails++;
                    end
                    if (got.flips_held !== want.flips_held) begin
                        $error("flips_held: expected %0d, actual %0d",
                               want.flips_held, got.flips_held);
                        fails++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_MIN_MOTION:   min_motion   = cfg_data[14:0];
                    REG_MAX_FLIP_GAP: max_gap      = cfg_data;
                    REG_FLIPS_NEEDED: flips_needed = cfg_data[4:0];
                    REG_WINDOW:       window_len   = cfg_data;
                    REG_IDLE_GAP:     idle_gap     = cfg_data;
                    REG_HOLD:         hold_len     = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                due_results.push_back(step_detector(in_data));
            pending <= due_results.size();
        end
    end

endmodule

// ===== sim/tb_shake_gesture_detector_unit.sv =====
// ----------------------------------------------------------------------------
// tb_shake_gesture_detector_unit
// Drives directed and random pointer requests through the shake detector
// under several register settings, with bursty requests and a stalling
// result side; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb_shake_gesture_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sgd_pkg::*;

    localparam logic [1:0]           KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int                   DRAIN_SLACK = 30;

    logic                  clk       = 1'b0;
    logic                  rst_n;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          fails;
    int          pending;
    int          sent_total = 0;
    int          burst_left = 0;
    logic [31:0] now_t      = '0;
    logic [15:0] rdy_tick   = '0;

    // settings in force, used to scale the random requests
    int cur_min;
    int cur_gap;
    int cur_hold;

    shake_gesture_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    shake_gesture_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: free flow, light stalls, heavy stalls, fixed duty pattern
    always @(posedge clk)
    begin
        rdy_tick <= rdy_tick + 16'd1;
        case (rdy_tick[10:9])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (rdy_tick[2:0] < 3'd3);
        endcase
    end

    task automatic send_req(logic [1:0] kind, logic [15:0] value, logic [31:0] stamp);
        in_item_t req;
        req.kind         = kind;
        req.value        = value;
        req.timestamp_us = stamp;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        sent_total++;
    endtask

    // hold off requests until every outstanding result has come back
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic configure(int mm, int gap, int flips, int win, int idle, int hold);
        logic [CFG_DATA_W-1:0] vals [8];
        vals[REG_MIN_MOTION]   = CFG_DATA_W'(mm);
        vals[REG_MAX_FLIP_GAP] = CFG_DATA_W'(gap);
        vals[REG_FLIPS_NEEDED] = CFG_DATA_W'(flips);
        vals[REG_WINDOW]       = CFG_DATA_W'(win);
        vals[REG_IDLE_GAP]     = CFG_DATA_W'(idle);
        vals[REG_HOLD]         = CFG_DATA_W'(hold);
        vals[REG_SPARE_A]      = CFG_DATA_W'($urandom);
        vals[REG_SPARE_B]      = CFG_DATA_W'($urandom);
        for (int k = 0; k < 8; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(k);
            cfg_data  <= vals[k];
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        cur_min  = mm;
        cur_gap  = gap;
        cur_hold = hold;
    endtask

    // time step between motions, mostly inside the flip gap
    function automatic int gap_step();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return $urandom_range(0, cur_gap);
        else if (r == 8)
            return cur_gap;
        return cur_gap + 1 + $urandom_range(0, cur_gap);
    endfunction

    function automatic logic [15:0] rel_value(logic up);
        int r;
        int mag;
        r = $urandom_range(0, 9);
        if (r == 0)
            mag = cur_min;
        else if (r == 1)
            mag = (cur_min > 0) ? cur_min - 1 : 0;
        else
            mag = $urandom_range(cur_min, 32767);
        if (!up && $urandom_range(0, 7) == 0)
            return 16'sh8000;
        return up ? 16'(mag) : 16'(-mag);
    endfunction

    // alternating strong motions, relative or absolute, then a few ticks
    task automatic shake_run();
        int   len;
        int   swing;
        int   lo;
        int   hi;
        int   nt;
        logic use_abs;
        logic up;
        len     = $urandom_range(3, 24);
        use_abs = ($urandom_range(0, 2) == 0);
        up      = $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0)
            swing = $urandom_range(0, cur_min);
        else
            swing = $urandom_range(cur_min, 65535);
        lo = -32768 + int'($urandom_range(0, 65535 - swing));
        hi = lo + swing;
        for (int k = 0; k < len; k++) begin
            now_t = now_t + 32'(gap_step());
            if ($urandom_range(0, 9) == 0)
                send_req(KIND_TICK, 16'($urandom), now_t);
            else if (use_abs)
                send_req(KIND_ABS, up ? 16'(hi) : 16'(lo), now_t);
            else
                send_req(KIND_REL, rel_value(up), now_t);
            if ($urandom_range(0, 5) != 0)
                up = !up;
        end
        nt = $urandom_range(0, 6);
        for (int k = 0; k < nt; k++) begin
            now_t = now_t + 32'($urandom_range(0, cur_hold / 3 + 1));
            send_req(KIND_TICK, 16'($urandom), now_t);
        end
    endtask

    task automatic noise_burst();
        int n;
        int r;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 5);
            case (r)
                0: ;
                1: now_t = now_t + $urandom;
                2: now_t = now_t + 32'h8000_0000 - 32'($urandom_range(0, 2));
                default: now_t = now_t + 32'($urandom_range(0, cur_gap * 2 + 2));
            endcase
            send_req(2'($urandom_range(0, 3)), 16'($urandom), now_t);
        end
    endtask

    task automatic run_phase(int mm, int gap, int flips, int win, int idle, int hold,
                             int n);
        int   start;
        logic paused;
        wait_quiet();
        repeat (DRAIN_SLACK) @(posedge clk);
        configure(mm, gap, flips, win, idle, hold);
        // some phases start just short of the timestamp wrap
        if ($urandom_range(0, 1) == 0)
            now_t = 32'hFFFF_0000 + 32'($urandom_range(0, 65535));
        else
            now_t = $urandom;
        start  = sent_total;
        paused = 1'b0;
        while (sent_total - start < n) begin
            if ($urandom_range(0, 9) < 7)
                shake_run();
            else
                noise_burst();
            if (!paused && sent_total - start >= n / 2) begin
                wait_quiet();
                paused = 1'b1;
            end
        end
    endtask

    task automatic directed_reqs();
        logic [31:0] dl;
        dl = 32'h60 + 32'd1500000;
        send_req(KIND_REL, 16'sd32767, 32'd1000);
        send_req(KIND_REL, -16'sd32768, 32'd1100);
        send_req(KIND_REL, 16'sd19, 32'd1150);          // below threshold
        send_req(KIND_REL, 16'sd20, 32'd1200);          // exactly at threshold
        send_req(KIND_REL, 16'sd0, 32'd1250);
        send_req(KIND_REL, -16'sd20, 32'd1300);         // third flip: shake
        send_req(KIND_TICK, 16'sd0, 32'd1501299);
        send_req(KIND_TICK, 16'sd0, 32'd1501300);       // tick on the deadline
        send_req(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        send_req(KIND_ABS, 16'sd32767, 32'd2000000);    // base set, no delta
        send_req(KIND_ABS, -16'sd32768, 32'd2000010);   // delta beyond 16 bits
        send_req(KIND_ABS, 16'sd32767, 32'd2000020);
        send_req(KIND_ABS, 16'sd0, 32'd2250021);        // idle pause: base rebuilt
        send_req(KIND_ABS, 16'sd0, 32'd2500021);        // pause equal to idle gap
        send_req(KIND_REL, 16'sd100, 32'hFFFF_FFF0);
        send_req(KIND_REL, -16'sd100, 32'h0000_0010);   // flip across the wrap
        send_req(KIND_REL, 16'sd100, 32'h20);
        send_req(KIND_REL, -16'sd100, 32'h30);
        send_req(KIND_REL, 16'sd100, 32'h40);
        send_req(KIND_REL, -16'sd100, 32'h50);
        send_req(KIND_REL, 16'sd100, 32'h60);           // shake while hold is on
        send_req(KIND_TICK, 16'sd0, dl + 32'h8000_0000);
        send_req(KIND_TICK, 16'sd0, dl - 32'd1);
        send_req(KIND_TICK, 16'sd0, dl + 32'h7FFF_FFFF);
        send_req(KIND_REL, -16'sd32768, 32'h60 + 32'd120001);
    endtask

    initial
    begin
        // driven at time zero so the falling edge reaches every reset block
        rst_n   <= 1'b0;
        cur_min  = int'(MIN_MOTION_RST);
        cur_gap  = int'(MAX_FLIP_GAP_RST);
        cur_hold = int'(HOLD_RST);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_reqs();
        run_phase(20, 120000, 3, 700000, 250000, 1500000, 300);
        run_phase(1, 16777215, 1, 16777215, 16777215, 16777215, 250);
        run_phase(32767, 0, 16, 0, 0, 0, 200);
        run_phase(100, 1000, 5, 5000, 2000, 3000, 300);
        run_phase(5, 500, 20, 16777215, 1000, 100, 250);  // window fills up
        run_phase(0, 10, 0, 50, 5, 20, 250);               // every flip fires
        run_phase(300, 40000, 31, 90000, 30000, 200000, 150);
        run_phase(7, 2000, 2, 3000, 1500, 8000, 250);
        wait_quiet();
        repeat (DRAIN_SLACK) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
